[rtl/core/potential_phase_rotator_defines.svh]
// Assertion macros for the potential phase rotator.
// No dependencies; each use expects signals named clock and reset in scope.
`ifndef POTENTIAL_PHASE_ROTATOR_DEFINES_SVH
`define POTENTIAL_PHASE_ROTATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ppr_pkg.sv]
// Shared constants for the potential phase rotator: field widths, CORDIC
// arctangent table and gain compensation constant. No dependencies.
`timescale 1ns / 1ps

package ppr_pkg;

   localparam int POT_W         = 32;  // potential, signed Q16.16
   localparam int PHASE_W       = 32;  // phase scale, signed Q8.24
   localparam int ANGLE_W       = 32;  // angle in 2^-32 turn units
   localparam int ANGLE_LSB     = 8;   // angle bits sit at [39:8] of the product
   localparam int GUARD_BITS    = 12;  // extra fraction bits inside the rotator
   localparam int HEADROOM_BITS = 3;   // room for sqrt(2) and CORDIC gain growth
   localparam int Z_W           = 34;  // residual angle accumulator
   localparam int ATAN_W        = 30;
   localparam int ATAN_LEN      = 40;
   localparam int GAIN_W        = 32;
   localparam logic [GAIN_W-1:0] GAIN_INV = 32'd2608131496;  // 1/K * 2^32

   typedef logic [ATAN_W-1:0] atan_type;

   // atan(2^-i) / (2*pi) * 2^32, rounded to nearest
   localparam atan_type ATAN_TABLE [ATAN_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
      30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
      30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
      30'd20,        30'd10,        30'd5,         30'd3,        30'd1,
      30'd1,         30'd0,         30'd0,         30'd0,        30'd0,
      30'd0,         30'd0,         30'd0,         30'd0,        30'd0
   };

endpackage

[rtl/core/ppr_interfaces.sv]
// Valid/ready channel interfaces for the potential phase rotator:
// cell request, rotated response and phase scale write. Depends on ppr_pkg.
`timescale 1ns / 1ps

interface ppr_req_if #(parameter int DATA_WIDTH = 32) ();
   logic                              valid;
   logic                              ready;
   logic signed [ppr_pkg::POT_W-1:0]  potential;
   logic signed [DATA_WIDTH-1:0]      psi_real;
   logic signed [DATA_WIDTH-1:0]      psi_imag;

   modport source (output valid, potential, psi_real, psi_imag, input ready);
   modport sink   (input valid, potential, psi_real, psi_imag, output ready);
endinterface

interface ppr_rsp_if #(parameter int DATA_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  rotated_real;
   logic signed [DATA_WIDTH-1:0]  rotated_imag;

   modport source (output valid, rotated_real, rotated_imag, input ready);
   modport sink   (input valid, rotated_real, rotated_imag, output ready);
endinterface

interface ppr_csr_if ();
   logic                                valid;
   logic                                ready;
   logic signed [ppr_pkg::PHASE_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[rtl/core/ppr_angle.sv]
// Front end of the rotator: angle multiply, then quarter-turn fold and
// extension of psi to the rotator width. Depends on ppr_pkg.
`timescale 1ns / 1ps

module ppr_angle #(
   parameter int DATA_WIDTH = 32,
   localparam int IW = DATA_WIDTH + ppr_pkg::GUARD_BITS + ppr_pkg::HEADROOM_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [ppr_pkg::PHASE_W-1:0] phase_scale,
   input  logic                               up_valid,
   output logic                               up_ready,
   input  logic signed [ppr_pkg::POT_W-1:0]   potential,
   input  logic signed [DATA_WIDTH-1:0]       psi_real,
   input  logic signed [DATA_WIDTH-1:0]       psi_imag,
   output logic                               dn_valid,
   input  logic                               dn_ready,
   output logic signed [IW-1:0]               x_dn,
   output logic signed [IW-1:0]               y_dn,
   output logic signed [ppr_pkg::Z_W-1:0]     z_dn,
   output logic [1:0]                         occ
);
   import ppr_pkg::*;

   localparam int PROD_W = POT_W + PHASE_W;

   logic                         a_valid_ff, a_valid_in;
   logic [ANGLE_W-1:0]           ang_ff, ang_in;
   logic signed [DATA_WIDTH-1:0] re_ff, re_in, im_ff, im_in;
   logic                         b_valid_ff, b_valid_in;
   logic signed [IW-1:0]         x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]        z_ff, z_in;
   logic                         a_ready, b_ready;
   logic signed [PROD_W-1:0]     prod;
   logic                         fold;
   logic [ANGLE_W-1:0]           ang_fold;
   logic signed [IW-1:0]         re_ext, im_ext;

   always_comb begin
      b_ready = !b_valid_ff || dn_ready;
      a_ready = !a_valid_ff || b_ready;

      // stage A: exact product, keep the fraction-of-turn window
      prod       = PROD_W'(potential) * PROD_W'(phase_scale);
      a_valid_in = a_ready ? up_valid : a_valid_ff;
      ang_in     = a_ready ? prod[ANGLE_LSB+ANGLE_W-1:ANGLE_LSB] : ang_ff;
      re_in      = a_ready ? psi_real : re_ff;
      im_in      = a_ready ? psi_imag : im_ff;

      // stage B: beyond a quarter turn, negate the vector and move half a turn
      fold       = ang_ff[ANGLE_W-1] ^ ang_ff[ANGLE_W-2];
      ang_fold   = {ang_ff[ANGLE_W-1] ^ fold, ang_ff[ANGLE_W-2:0]};
      re_ext     = IW'(re_ff) <<< GUARD_BITS;
      im_ext     = IW'(im_ff) <<< GUARD_BITS;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      x_in       = b_ready ? (fold ? -re_ext : re_ext) : x_ff;
      y_in       = b_ready ? (fold ? -im_ext : im_ext) : y_ff;
      z_in       = b_ready ? Z_W'($signed(ang_fold)) : z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff <= ang_in;
      re_ff  <= re_in;
      im_ff  <= im_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign up_ready = a_ready;
   assign dn_valid = b_valid_ff;
   assign x_dn     = x_ff;
   assign y_dn     = y_ff;
   assign z_dn     = z_ff;
   assign occ      = {b_valid_ff, a_valid_ff};

endmodule

[rtl/core/ppr_cordic_cell.sv]
// One CORDIC rotation cell: a single micro-rotation by atan(2^-STAGE)
// with its own pipeline register. Depends on ppr_pkg.
`timescale 1ns / 1ps

module ppr_cordic_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int STAGE = 0,
   localparam int IW = DATA_WIDTH + ppr_pkg::GUARD_BITS + ppr_pkg::HEADROOM_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           up_valid,
   output logic                           up_ready,
   input  logic signed [IW-1:0]           x_up,
   input  logic signed [IW-1:0]           y_up,
   input  logic signed [ppr_pkg::Z_W-1:0] z_up,
   output logic                           dn_valid,
   input  logic                           dn_ready,
   output logic signed [IW-1:0]           x_dn,
   output logic signed [IW-1:0]           y_dn,
   output logic signed [ppr_pkg::Z_W-1:0] z_dn
);
   import ppr_pkg::*;

   localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(ATAN_TABLE[STAGE]);

   logic                  valid_ff, valid_in;
   logic signed [IW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0] z_ff, z_in;
   logic                  ready;
   logic signed [IW-1:0]  dx, dy;

   always_comb begin
      ready    = !valid_ff || dn_ready;
      dx       = y_up >>> STAGE;
      dy       = x_up >>> STAGE;
      valid_in = ready ? up_valid : valid_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      if (ready) begin
         if (!z_up[Z_W-1]) begin
            x_in = x_up + dx;
            y_in = y_up - dy;
            z_in = z_up - ATAN_Z;
         end else begin
            x_in = x_up - dx;
            y_in = y_up + dy;
            z_in = z_up + ATAN_Z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign up_ready = ready;
   assign dn_valid = valid_ff;
   assign x_dn     = x_ff;
   assign y_dn     = y_ff;
   assign z_dn     = z_ff;

endmodule

[rtl/core/ppr_gain.sv]
// Back end of the rotator: gain compensation (magnitude times 1/K, truncated
// toward zero), then rounding and saturation to DATA_WIDTH. Depends on ppr_pkg.
`timescale 1ns / 1ps

module ppr_gain #(
   parameter int DATA_WIDTH = 32,
   localparam int IW = DATA_WIDTH + ppr_pkg::GUARD_BITS + ppr_pkg::HEADROOM_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  logic signed [IW-1:0]         x_up,
   input  logic signed [IW-1:0]         y_up,
   output logic                         dn_valid,
   input  logic                         dn_ready,
   output logic signed [DATA_WIDTH-1:0] rotated_real,
   output logic signed [DATA_WIDTH-1:0] rotated_imag,
   output logic [3:0]                   occ
);
   import ppr_pkg::*;

   localparam int LANES = 2;
   localparam int MW    = (IW > GAIN_W) ? IW : GAIN_W + 1;  // magnitude width
   localparam int LP_W  = 2 * GAIN_W;
   localparam int RND_W = IW + 1;
   localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (GUARD_BITS - 1);
   localparam logic signed [RND_W-1:0] SAT_HI =
      (RND_W'(1) <<< (DATA_WIDTH - 1)) - RND_W'(1);
   localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

   logic [3:0]                   valid_ff, valid_in;
   logic [3:0]                   ready;
   logic signed [IW-1:0]         lane_up   [LANES];
   logic [IW-1:0]                abs_u     [LANES];
   logic                         neg1_ff   [LANES], neg1_in [LANES];
   logic [MW-1:0]                mag1_ff   [LANES], mag1_in [LANES];
   logic                         neg2_ff   [LANES], neg2_in [LANES];
   logic [MW-1:0]                hi2_ff    [LANES], hi2_in  [LANES];
   logic [GAIN_W-1:0]            lo2_ff    [LANES], lo2_in  [LANES];
   logic [LP_W-1:0]              lo_prod   [LANES];
   logic [MW-1:0]                prod_sum  [LANES];
   logic signed [IW-1:0]         v3_ff     [LANES], v3_in   [LANES];
   logic signed [RND_W-1:0]      rnd       [LANES];
   logic signed [RND_W-1:0]      shifted   [LANES];
   logic signed [DATA_WIDTH-1:0] out_ff    [LANES], out_in  [LANES];

   assign lane_up[0] = x_up;
   assign lane_up[1] = y_up;

   always_comb begin
      ready[3] = !valid_ff[3] || dn_ready;
      ready[2] = !valid_ff[2] || ready[3];
      ready[1] = !valid_ff[1] || ready[2];
      ready[0] = !valid_ff[0] || ready[1];
      valid_in[0] = ready[0] ? up_valid    : valid_ff[0];
      valid_in[1] = ready[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = ready[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = ready[3] ? valid_ff[2] : valid_ff[3];

      for (int i = 0; i < LANES; i++) begin
         // sign and magnitude
         abs_u[i]   = lane_up[i][IW-1] ? IW'(-lane_up[i]) : lane_up[i];
         neg1_in[i] = ready[0] ? lane_up[i][IW-1] : neg1_ff[i];
         mag1_in[i] = ready[0] ? MW'(abs_u[i]) : mag1_ff[i];

         // two partial products of magnitude * 1/K
         lo_prod[i] = LP_W'(mag1_ff[i][GAIN_W-1:0]) * LP_W'(GAIN_INV);
         neg2_in[i] = ready[1] ? neg1_ff[i] : neg2_ff[i];
         hi2_in[i]  = ready[1] ? MW'(mag1_ff[i][MW-1:GAIN_W]) * MW'(GAIN_INV)
                               : hi2_ff[i];
         lo2_in[i]  = ready[1] ? lo_prod[i][LP_W-1:GAIN_W] : lo2_ff[i];

         // combine and restore the sign
         prod_sum[i] = hi2_ff[i] + MW'(lo2_ff[i]);
         v3_in[i]    = ready[2] ? (neg2_ff[i] ? -$signed(IW'(prod_sum[i]))
                                              : $signed(IW'(prod_sum[i])))
                                : v3_ff[i];

         // round half up, drop guard bits, saturate
         rnd[i]     = RND_W'(v3_ff[i]) + RND_HALF;
         shifted[i] = rnd[i] >>> GUARD_BITS;
         out_in[i]  = out_ff[i];
         if (ready[3]) begin
            priority if (shifted[i] > SAT_HI) begin
               out_in[i] = SAT_HI[DATA_WIDTH-1:0];
            end else if (shifted[i] < SAT_LO) begin
               out_in[i] = SAT_LO[DATA_WIDTH-1:0];
            end else begin
               out_in[i] = shifted[i][DATA_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         neg1_ff[i] <= neg1_in[i];
         mag1_ff[i] <= mag1_in[i];
         neg2_ff[i] <= neg2_in[i];
         hi2_ff[i]  <= hi2_in[i];
         lo2_ff[i]  <= lo2_in[i];
         v3_ff[i]   <= v3_in[i];
         out_ff[i]  <= out_in[i];
      end
   end

   assign up_ready     = ready[0];
   assign dn_valid     = valid_ff[3];
   assign rotated_real = out_ff[0];
   assign rotated_imag = out_ff[1];
   assign occ          = valid_ff;

endmodule

[rtl/core/potential_phase_rotator.sv]
// Potential phase rotator: psi * exp(-i*2*pi*potential*phase_scale).
// Throughput: one transaction per cycle while responses are accepted; every stage
// register is its own cell, so a stalled response holds only as many stages as it must.
// Reset (synchronous, active high) empties the pipe and clears phase_scale.
`timescale 1ns / 1ps
`include "potential_phase_rotator_defines.svh"

module potential_phase_rotator #(
   parameter int DATA_WIDTH    = 32,
   parameter int CORDIC_STAGES = 24
) (
   input logic        clock,
   input logic        reset,
   ppr_req_if.sink    req_bus,
   ppr_rsp_if.source  rsp_bus,
   ppr_csr_if.sink    csr_bus
);
   import ppr_pkg::*;

   localparam int IW      = DATA_WIDTH + GUARD_BITS + HEADROOM_BITS;
   localparam int NUM_OCC = 2 + CORDIC_STAGES + 4;   // all pipeline registers
   localparam int CNT_W   = $clog2(NUM_OCC + 1);

   // ------------------------------------------------------------------
   // Phase scale register. Always ready; the user must see that it is written only
   // while the pipe is idle (the block does not enforce this), so no shadowing is needed.
   // ------------------------------------------------------------------
   logic signed [PHASE_W-1:0] scale_ff, scale_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      scale_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : scale_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
      end else begin
         scale_ff <= scale_in;
      end
   end

   // ------------------------------------------------------------------
   // Data chain: angle front end -> CORDIC_STAGES cells -> gain back end.
   // Each hop is a valid/ready pair; a cell takes new data whenever it is
   // empty or its neighbor takes its current contents.
   // ------------------------------------------------------------------
   logic signed [IW-1:0]  x_chain [CORDIC_STAGES+1];
   logic signed [IW-1:0]  y_chain [CORDIC_STAGES+1];
   logic signed [Z_W-1:0] z_chain [CORDIC_STAGES+1];
   logic [CORDIC_STAGES:0] valid_chain;
   logic [CORDIC_STAGES:0] ready_chain;
   logic [1:0]             angle_occ;
   logic [3:0]             gain_occ;

   // angle = potential * scale, bits [39:8] of the Q24.40 product;
   // whole turns fall off the top for free
   ppr_angle #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_angle (
      .clock       (clock),
      .reset       (reset),
      .phase_scale (scale_ff),
      .up_valid    (req_bus.valid),
      .up_ready    (req_bus.ready),
      .potential   (req_bus.potential),
      .psi_real    (req_bus.psi_real),
      .psi_imag    (req_bus.psi_imag),
      .dn_valid    (valid_chain[0]),
      .dn_ready    (ready_chain[0]),
      .x_dn        (x_chain[0]),
      .y_dn        (y_chain[0]),
      .z_dn        (z_chain[0]),
      .occ         (angle_occ)
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      ppr_cordic_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .STAGE      (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_chain[g]),
         .up_ready (ready_chain[g]),
         .x_up     (x_chain[g]),
         .y_up     (y_chain[g]),
         .z_up     (z_chain[g]),
         .dn_valid (valid_chain[g+1]),
         .dn_ready (ready_chain[g+1]),
         .x_dn     (x_chain[g+1]),
         .y_dn     (y_chain[g+1]),
         .z_dn     (z_chain[g+1])
      );
   end

   // residual angle of the last cell is not needed
   ppr_gain #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_gain (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (valid_chain[CORDIC_STAGES]),
      .up_ready     (ready_chain[CORDIC_STAGES]),
      .x_up         (x_chain[CORDIC_STAGES]),
      .y_up         (y_chain[CORDIC_STAGES]),
      .dn_valid     (rsp_bus.valid),
      .dn_ready     (rsp_bus.ready),
      .rotated_real (rsp_bus.rotated_real),
      .rotated_imag (rsp_bus.rotated_imag),
      .occ          (gain_occ)
   );

   // ------------------------------------------------------------------
   // Checks: transactions in flight match occupied stages, back pressure
   // reaches the request side only with a full pipe, folded angle stays
   // within a quarter turn, and a register write lands.
   // ------------------------------------------------------------------
   logic [NUM_OCC-1:0] occ_vec;
   logic [CNT_W-1:0]   inflight_ff, inflight_in;

   assign occ_vec = {gain_occ, valid_chain[CORDIC_STAGES:1], angle_occ};

   always_comb begin
      inflight_in = inflight_ff
                  + CNT_W'(req_bus.valid && req_bus.ready)
                  - CNT_W'(rsp_bus.valid && rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `PPR_ASSERT_NOW(a_inflight_count, 1'b1, $countones(occ_vec) == inflight_ff, "in-flight count differs from occupied stages")
   `PPR_ASSERT_NOW(a_stall_full, !req_bus.ready, &occ_vec, "request stalled with an empty stage")
   `PPR_ASSERT_NOW(a_fold_range, valid_chain[0], (&z_chain[0][Z_W-1:ANGLE_W-2]) || (~|z_chain[0][Z_W-1:ANGLE_W-2]), "folded angle beyond a quarter turn")
   `PPR_ASSERT_NEXT(a_scale_write, csr_bus.valid && csr_bus.ready, scale_ff == $past(csr_bus.data), "phase scale write lost")

endmodule
